FILE: hdl/abd_pkg.sv
// Shared types, constants and helper functions for the anchor box detection decoder.
// No dependencies.
package abd_pkg;

  localparam int LOGIT_W      = 16;
  localparam int PROB_W       = 16;
  localparam int COORD_W      = 18;
  localparam int MAX_CLASSES  = 16;
  localparam int MAX_COLORS   = 8;
  localparam int MAX_GRID     = 256;
  localparam int MAX_ANCHORS  = 3;
  localparam int NUM_BOX      = 5;
  localparam int NUM_KEY      = 10;
  localparam int FIXED_CH     = NUM_BOX + NUM_KEY;
  localparam int MAX_CHANNELS = FIXED_CH + MAX_CLASSES + MAX_COLORS;
  localparam int CH_W         = 6;
  localparam int POS_W        = 8;
  localparam int ANC_W        = 2;
  localparam int CLS_W        = 4;
  localparam int COLR_W       = 3;
  localparam int KIND_W       = 3;
  localparam int ITER_W       = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 60;
  localparam int ANCHOR_DIM_W = 10;

  localparam logic [16:0]       LOG2E_Q16  = 17'd94548;
  localparam logic [ITER_W-1:0] EXP_LAST   = 5'd9;
  localparam logic [ITER_W-1:0] DIV_LAST   = 5'd16;
  localparam logic [ITER_W-1:0] ROOT_LAST  = 5'd15;
  localparam logic [ITER_W-1:0] POINT_LAST = 5'd6;
  localparam logic [KIND_W-1:0] KIND_LAST  = 3'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE      = 3'd0,
    CFG_STRIDE_LOG2    = 3'd1,
    CFG_NUM_ANCHORS    = 3'd2,
    CFG_NUM_CLASSES    = 3'd3,
    CFG_NUM_COLORS     = 3'd4,
    CFG_CONF_THRESHOLD = 3'd5,
    CFG_ANCHOR_SIZES   = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_KEY_STORE, OP_SIG_MUL, OP_SIG_EXP, OP_SIG_SHIFT, OP_SIG_DIV,
    OP_SIG_STORE, OP_ROOT_MUL, OP_ROOT_STEP, OP_CONF, OP_SQ_W, OP_SQ_H, OP_HALF_W,
    OP_HALF_H, OP_KP_READ, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic is_key;
    logic end_of_cell;
    logic pass;
    logic out_free;
  } status_t;

  // round(65536 * 2^(-2^-(i+1)))
  function automatic logic [15:0] pow2_frac(input logic [3:0] i);
    logic [15:0] t;
    unique case (i)
      4'd0: t = 16'd46341;
      4'd1: t = 16'd55109;
      4'd2: t = 16'd60097;
      4'd3: t = 16'd62757;
      4'd4: t = 16'd64132;
      4'd5: t = 16'd64830;
      4'd6: t = 16'd65182;
      4'd7: t = 16'd65359;
      4'd8: t = 16'd65447;
      4'd9: t = 16'd65492;
      default: t = 16'd65535;
    endcase
    return t;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [55:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 56'sd131071) r = 18'sh1FFFF;
    else if (v < -56'sd131072) r = 18'sh20000;
    else r = v[COORD_W-1:0];
    return r;
  endfunction

endpackage

FILE: hdl/abd_in_if.sv
// Input channel: one logit beat with valid/ready.
// Depends on abd_pkg.
interface abd_in_if import abd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [LOGIT_W-1:0] logit;
  logic                      first_of_layer;

  modport source (output valid, logit, first_of_layer, input ready);
  modport sink (input valid, logit, first_of_layer, output ready);
endinterface

FILE: hdl/abd_out_if.sv
// Output channel: one detection point beat with valid/ready.
// Depends on abd_pkg.
interface abd_out_if import abd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         point_kind;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic [PROB_W-1:0]         confidence;
  logic [CLS_W-1:0]          class_id;
  logic [COLR_W-1:0]         color_id;
  logic                      last_of_detection;

  modport source (output valid, point_kind, x_coord, y_coord, confidence, class_id,
                  color_id, last_of_detection, input ready);
  modport sink (input valid, point_kind, x_coord, y_coord, confidence, class_id,
                color_id, last_of_detection, output ready);
endinterface

FILE: hdl/abd_ctrl.sv
// Sequencer for the decoder: walks sigmoid, root, compare and point emit steps.
// Depends on abd_pkg; drives the command of abd_dp.
module abd_ctrl import abd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_DISP  = 15'b000000000000010,
    S_EXP   = 15'b000000000000100,
    S_SHIFT = 15'b000000000001000,
    S_DIV   = 15'b000000000010000,
    S_STORE = 15'b000000000100000,
    S_RMUL  = 15'b000000001000000,
    S_ROOT  = 15'b000000010000000,
    S_CONF  = 15'b000000100000000,
    S_PASS  = 15'b000001000000000,
    S_SQH   = 15'b000010000000000,
    S_HW    = 15'b000100000000000,
    S_HH    = 15'b001000000000000,
    S_RD    = 15'b010000000000000,
    S_EMIT  = 15'b100000000000000
  } state_t;

  state_t            state, state_next;
  logic [ITER_W-1:0] iter, iter_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd.op     = OP_NONE;
    cmd.iter   = iter;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (status.is_key) begin
          cmd.op     = OP_KEY_STORE;
          state_next = status.end_of_cell ? S_RMUL : S_IDLE;
        end else begin
          cmd.op     = OP_SIG_MUL;
          iter_next  = '0;
          state_next = S_EXP;
        end
      end
      S_EXP: begin
        cmd.op    = OP_SIG_EXP;
        iter_next = iter + 5'd1;
        if (iter == EXP_LAST) state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.op     = OP_SIG_SHIFT;
        iter_next  = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op    = OP_SIG_DIV;
        iter_next = iter + 5'd1;
        if (iter == DIV_LAST) state_next = S_STORE;
      end
      S_STORE: begin
        cmd.op     = OP_SIG_STORE;
        state_next = status.end_of_cell ? S_RMUL : S_IDLE;
      end
      S_RMUL: begin
        cmd.op     = OP_ROOT_MUL;
        iter_next  = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.op    = OP_ROOT_STEP;
        iter_next = iter + 5'd1;
        if (iter == ROOT_LAST) state_next = S_CONF;
      end
      S_CONF: begin
        cmd.op     = OP_CONF;
        state_next = S_PASS;
      end
      S_PASS: begin
        if (status.pass) begin
          cmd.op     = OP_SQ_W;
          state_next = S_SQH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SQH: begin
        cmd.op     = OP_SQ_H;
        state_next = S_HW;
      end
      S_HW: begin
        cmd.op     = OP_HALF_W;
        state_next = S_HH;
      end
      S_HH: begin
        cmd.op     = OP_HALF_H;
        iter_next  = '0;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.op     = OP_KP_READ;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op    = OP_EMIT;
          iter_next = iter + 5'd1;
          state_next = (iter == POINT_LAST) ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> state == S_DISP)
    else $error("accepted beat not dispatched");

  a_last_point_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && status.out_free && iter == POINT_LAST) |=> state == S_IDLE)
    else $error("emit did not stop after last point");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> iter <= DIV_LAST)
    else $error("divider iteration overrun");

endmodule

FILE: hdl/abd_dp.sv
// Datapath: config registers, cell counters, sigmoid/divide/root units, coordinates.
// Depends on abd_pkg; driven by abd_ctrl.
module abd_dp import abd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [LOGIT_W-1:0]  logit,
  input  logic                       first_of_layer,
  input  cmd_t                       cmd,
  output status_t                    status,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [KIND_W-1:0]          out_kind,
  output logic signed [COORD_W-1:0]  out_x,
  output logic signed [COORD_W-1:0]  out_y,
  output logic [PROB_W-1:0]          out_conf,
  output logic [CLS_W-1:0]           out_class,
  output logic [COLR_W-1:0]          out_color,
  output logic                       out_last
);

  // configuration
  logic [8:0]            grid_size;
  logic [2:0]            stride_log2;
  logic [1:0]            anchor_count;
  logic [4:0]            class_count;
  logic [3:0]            color_count;
  logic [PROB_W-1:0]     conf_threshold;
  logic [CFG_DATA_W-1:0] anchor_sizes;

  // cell position
  logic [CH_W-1:0]  ch;
  logic [POS_W-1:0] col, row, cur_col, cur_row;
  logic [ANC_W-1:0] anc, cur_anc;

  // per-cell values
  logic signed [LOGIT_W-1:0] x;
  logic [PROB_W-1:0]         box [NUM_BOX];
  logic signed [LOGIT_W-1:0] kp [NUM_KEY];
  logic [PROB_W-1:0]         best_cls, best_col;
  logic [CLS_W-1:0]          best_cls_idx;
  logic [COLR_W-1:0]         best_col_idx;

  // sigmoid and root working registers
  logic [31:0] u;
  logic [16:0] e;
  logic [17:0] rem, den_r;
  logic [16:0] num_lo, q;
  logic [31:0] v;
  logic [15:0] root;
  logic [PROB_W-1:0] conf;

  // coordinate working registers
  logic [33:0]        sqw, sqh;
  logic [43:0]        hw, hh;
  logic signed [55:0] xbig, ybig;
  logic signed [LOGIT_W-1:0] kx, ky;

  // clamped configuration
  logic [4:0]      nc;
  logic [3:0]      ncol;
  logic [8:0]      grid;
  logic [1:0]      na;
  logic [CH_W-1:0] n_ch, class_end;
  logic            eoc;

  always_comb begin
    nc   = (class_count == 5'd0) ? 5'd1 :
           (class_count > 5'(MAX_CLASSES)) ? 5'(MAX_CLASSES) : class_count;
    ncol = (color_count == 4'd0) ? 4'd1 :
           (color_count > 4'(MAX_COLORS)) ? 4'(MAX_COLORS) : color_count;
    grid = (grid_size == 9'd0) ? 9'd1 :
           (grid_size > 9'(MAX_GRID)) ? 9'(MAX_GRID) : grid_size;
    na   = (anchor_count == 2'd0) ? 2'd1 :
           (anchor_count > 2'(MAX_ANCHORS)) ? 2'(MAX_ANCHORS) : anchor_count;
    class_end = 6'(FIXED_CH) + 6'(nc);
    n_ch      = class_end + 6'(ncol);
    eoc       = ({1'b0, ch} + 7'd1) >= {1'b0, n_ch};
  end

  assign status.is_key      = (ch >= 6'(NUM_BOX)) && (ch < 6'(FIXED_CH));
  assign status.end_of_cell = eoc;
  assign status.pass        = conf > conf_threshold;
  assign status.out_free    = !out_valid || out_ready;

  // anchor dimensions of the latched cell
  logic [ANCHOR_DIM_W-1:0] aw, ah;
  always_comb begin
    unique case (cur_anc)
      2'd0: begin aw = anchor_sizes[9:0];   ah = anchor_sizes[19:10]; end
      2'd1: begin aw = anchor_sizes[29:20]; ah = anchor_sizes[39:30]; end
      2'd2: begin aw = anchor_sizes[49:40]; ah = anchor_sizes[59:50]; end
      default: begin aw = '0; ah = '0; end
    endcase
  end

  // sigmoid helpers
  logic [16:0] mag;
  logic [33:0] ep;
  logic [16:0] es;
  logic [17:0] den;
  logic [32:0] num;
  logic [18:0] rem2;
  logic [PROB_W-1:0] sv;
  logic [4:0]  fbit;

  always_comb begin
    mag  = x[LOGIT_W-1] ? 17'(-{x[LOGIT_W-1], x}) : {1'b0, x};
    fbit = 5'd23 - cmd.iter;
    ep   = 34'(e) * 34'(pow2_frac(cmd.iter[3:0])) + 34'd32768;
    es   = (u[31:24] >= 8'd17) ? 17'd0 : (e >> u[28:24]);
    den  = 18'h10000 + {1'b0, es};
    num  = 33'h1_0000_0000 + {16'd0, den[17:1]};
    rem2 = {rem, num_lo[16]};
    sv   = x[LOGIT_W-1] ? 16'(17'h10000 - q) : (q[16] ? 16'hFFFF : q[15:0]);
  end

  // root helpers
  logic [3:0]  rbit;
  logic [15:0] rtry;
  logic [31:0] rsq;
  always_comb begin
    rbit = 4'd15 - cmd.iter[3:0];
    rtry = root | (16'd1 << rbit);
    rsq  = rtry * rtry;
  end

  // coordinate helpers
  logic signed [25:0] xq, yq;
  logic [3:0]         kidx;
  logic signed [26:0] kxp, kyp;
  logic [27:0]        cs, rs;
  logic signed [27:0] kxs, kys;
  logic signed [55:0] px, py;

  always_comb begin
    xq   = $signed({2'b00, cur_col, 16'd0}) + $signed({9'd0, box[0], 1'b0}) - 26'sd32768;
    yq   = $signed({2'b00, cur_row, 16'd0}) + $signed({9'd0, box[1], 1'b0}) - 26'sd32768;
    kidx = (cmd.iter >= 5'd2) ? 4'((cmd.iter - 5'd2) << 1) : 4'd0;
    kxp  = kx * $signed({1'b0, aw});
    kyp  = ky * $signed({1'b0, ah});
    cs   = 28'(cur_col) << (5'(stride_log2) + 5'd10);
    rs   = 28'(cur_row) << (5'(stride_log2) + 5'd10);
    kxs  = $signed({kxp[26], kxp}) + $signed(cs);
    kys  = $signed({kyp[26], kyp}) + $signed(rs);
    unique case (cmd.iter)
      5'd0: begin
        px = (xbig - $signed({12'd0, hw})) >>> 31;
        py = (ybig - $signed({12'd0, hh})) >>> 31;
      end
      5'd1: begin
        px = (xbig + $signed({12'd0, hw})) >>> 31;
        py = (ybig + $signed({12'd0, hh})) >>> 31;
      end
      default: begin
        px = 56'(kxs >>> 6);
        py = 56'(kys >>> 6);
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size      <= 9'd80;
      stride_log2    <= 3'd3;
      anchor_count   <= 2'd3;
      class_count    <= 5'd8;
      color_count    <= 4'd4;
      conf_threshold <= 16'd32768;
      anchor_sizes   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_SIZE:      grid_size      <= cfg_data[8:0];
        CFG_STRIDE_LOG2:    stride_log2    <= cfg_data[2:0];
        CFG_NUM_ANCHORS:    anchor_count   <= cfg_data[1:0];
        CFG_NUM_CLASSES:    class_count    <= cfg_data[4:0];
        CFG_NUM_COLORS:     color_count    <= cfg_data[3:0];
        CFG_CONF_THRESHOLD: conf_threshold <= cfg_data[15:0];
        CFG_ANCHOR_SIZES:   anchor_sizes   <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state: counters, best scores, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ch           <= '0;
      col          <= '0;
      row          <= '0;
      anc          <= '0;
      best_cls     <= '0;
      best_cls_idx <= '0;
      best_col     <= '0;
      best_col_idx <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.op == OP_LOAD && first_of_layer) begin
        ch  <= '0;
        col <= '0;
        row <= '0;
        anc <= '0;
      end
      if (cmd.op == OP_SIG_STORE && ch >= 6'(FIXED_CH)) begin
        if (ch < class_end) begin
          if (ch == 6'(FIXED_CH) || sv > best_cls) begin
            best_cls     <= sv;
            best_cls_idx <= 4'(ch - 6'(FIXED_CH));
          end
        end else if (ch == class_end || sv > best_col) begin
          best_col     <= sv;
          best_col_idx <= 3'(ch - class_end);
        end
      end
      if (cmd.op == OP_KEY_STORE || cmd.op == OP_SIG_STORE) begin
        if (!eoc) begin
          ch <= ch + 6'd1;
        end else begin
          ch <= '0;
          if ({1'b0, col} + 9'd1 >= grid) begin
            col <= '0;
            if ({1'b0, row} + 9'd1 >= grid) begin
              row <= '0;
              anc <= ({1'b0, anc} + 3'd1 >= {1'b0, na}) ? 2'd0 : anc + 2'd1;
            end else begin
              row <= row + 8'd1;
            end
          end else begin
            col <= col + 8'd1;
          end
        end
      end
      if (cmd.op == OP_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers and working values
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: x <= logit;
      OP_KEY_STORE: begin
        kp[4'(ch - 6'(NUM_BOX))] <= x;
        if (eoc) begin
          cur_col <= col;
          cur_row <= row;
          cur_anc <= anc;
        end
      end
      OP_SIG_MUL: begin
        u <= 32'(mag) * 32'(LOG2E_Q16);
        e <= 17'h10000;
      end
      OP_SIG_EXP: if (u[fbit]) e <= ep[32:16];
      OP_SIG_SHIFT: begin
        rem    <= {2'b00, num[32:17]};
        num_lo <= num[16:0];
        den_r  <= den;
        q      <= '0;
      end
      OP_SIG_DIV: begin
        if (rem2 >= {1'b0, den_r}) begin
          rem <= 18'(rem2 - {1'b0, den_r});
          q   <= {q[15:0], 1'b1};
        end else begin
          rem <= rem2[17:0];
          q   <= {q[15:0], 1'b0};
        end
        num_lo <= {num_lo[15:0], 1'b0};
      end
      OP_SIG_STORE: begin
        if (ch < 6'(NUM_BOX)) box[3'(ch)] <= sv;
        if (eoc) begin
          cur_col <= col;
          cur_row <= row;
          cur_anc <= anc;
        end
      end
      OP_ROOT_MUL: begin
        v    <= best_cls * best_col;
        root <= '0;
      end
      OP_ROOT_STEP: if (rsq <= v) root <= rtry;
      OP_CONF: conf <= 16'((32'(box[4]) * 32'(root)) >> 16);
      OP_SQ_W: begin
        sqw  <= {box[2], 1'b0} * {box[2], 1'b0};
        xbig <= $signed({{30{xq[25]}}, xq}) <<< (5'(stride_log2) + 5'd19);
      end
      OP_SQ_H: begin
        sqh  <= {box[3], 1'b0} * {box[3], 1'b0};
        ybig <= $signed({{30{yq[25]}}, yq}) <<< (5'(stride_log2) + 5'd19);
      end
      OP_HALF_W: hw <= sqw * 44'(aw);
      OP_HALF_H: hh <= sqh * 44'(ah);
      OP_KP_READ: begin
        kx <= kp[kidx];
        ky <= kp[kidx + 4'd1];
      end
      OP_EMIT: begin
        out_kind  <= cmd.iter[2:0];
        out_x     <= sat_coord(px);
        out_y     <= sat_coord(py);
        out_conf  <= conf;
        out_class <= best_cls_idx;
        out_color <= best_col_idx;
        out_last  <= (cmd.iter == POINT_LAST);
      end
      default: ;
    endcase
  end

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_kind == KIND_LAST)))
    else $error("last flag not on final point");

  a_channel_bound: assert property (@(posedge clk) disable iff (rst)
    ch <= 6'(MAX_CHANNELS - 1))
    else $error("channel index past widest cell");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |=> out_valid)
    else $error("emitted point not presented");

endmodule

FILE: hdl/anchor_box_detection_decoder_top.sv
// Top level of the anchor box detection decoder.
// Depends on abd_pkg, abd_in_if, abd_out_if, abd_ctrl and abd_dp.
//
// Decodes one output layer of an anchor-based detector, one Q8.8 logit per beat
// in anchor/row/column cell order. Each cell carries 15 + classes + colors
// channels; channels 0-4, classes and colors pass through a sigmoid, keypoint
// offsets are kept raw, and class and color argmax keep the first maximum.
// At the last channel of a cell, confidence = obj * sqrt(class * color); when it
// is strictly above conf_threshold the block emits seven points (box top-left,
// box bottom-right, five keypoints) in Q13.4, saturated. Items are taken one at
// a time. A keypoint beat is only stored; every other beat runs the sigmoid unit:
// a 10-step exponent multiply loop plus a 17-step restoring divider. The last beat
// of a cell adds the 16-step bit-by-bit square root and the threshold compare, and
// a passing cell the box size products, then a read and an emit step per point
// (the emit waits while the sink stalls). The result sits in an output register,
// so the sink may hold off ready without losing a point. Configuration is written
// through cfg_we/cfg_index/cfg_data and must only change while the block is idle.
module anchor_box_detection_decoder_top import abd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  abd_in_if.sink                in,
  abd_out_if.source             out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in.ready = in_ready;

  // sequencer
  abd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, counters and the output register
  abd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .logit          (in.logit),
    .first_of_layer (in.first_of_layer),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out.ready),
    .out_valid      (out.valid),
    .out_kind       (out.point_kind),
    .out_x          (out.x_coord),
    .out_y          (out.y_coord),
    .out_conf       (out.confidence),
    .out_class      (out.class_id),
    .out_color      (out.color_id),
    .out_last       (out.last_of_detection)
  );

endmodule

FILE: dv/abd_checker.sv
// Scoreboard for the anchor box detection decoder: tracks register writes,
// predicts the detection points of each accepted logit beat and compares them.
// Depends on abd_pkg, abd_in_if and abd_out_if.
module abd_checker import abd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  abd_in_if                     logit_ch,
  abd_out_if                    point_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [PROB_W-1:0]         conf;
    logic [CLS_W-1:0]          cls;
    logic [COLR_W-1:0]         colr;
    logic                      last;
  } point_t;

  point_t point_q[$];

  // 2^(-2^-(i+1)) in Q0.16
  localparam int unsigned EXP_TBL[10] = '{46341, 55109, 60097, 62757, 64132,
                                          64830, 65182, 65359, 65447, 65492};

  logic [8:0]  grid_r;
  logic [2:0]  stride_r;
  logic [1:0]  anchors_r;
  logic [4:0]  classes_r;
  logic [3:0]  colors_r;
  logic [15:0] thresh_r;
  logic [59:0] asize_r;

  int unsigned chan, col, row, anc;
  int unsigned box_p[5];
  longint      key_off[10];
  int unsigned cls_best, cls_idx, colr_best, colr_idx;

  function automatic int unsigned sigmoid_q16(logic signed [15:0] x);
    longint unsigned mag, u, k, e, den, p;
    int unsigned fr;
    mag = (x < 0) ? longint'(-longint'(x)) : longint'(x);
    u = mag * 94548;
    k = u >> 24;
    fr = (u >> 14) & 1023;
    e = 0;
    if (k < 17) begin
      e = 65536;
      for (int i = 0; i < 10; i++)
        if (fr & (512 >> i)) e = (e * EXP_TBL[i] + 32768) >> 16;
      e = e >> k;
    end
    den = 65536 + e;
    p = ((64'd1 << 32) + den / 2) / den;
    if (x >= 0) return (p > 65535) ? 65535 : p;
    return 65536 - p;
  endfunction

  function automatic int unsigned root32(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] clip(longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[COORD_W-1:0];
  endfunction

  task automatic decode_beat(logic signed [15:0] x, logic first);
    int unsigned nc, ncol, n, grid, na, ch, c, r, a, rt, conf, s, sv;
    longint aw, ah, sqw, sqh, xc, yc;
    longint px[7], py[7];
    point_t pt;
    if (first) begin
      chan = 0; col = 0; row = 0; anc = 0;
    end
    nc   = (classes_r < 1) ? 1 : ((classes_r > MAX_CLASSES) ? MAX_CLASSES : classes_r);
    ncol = (colors_r < 1) ? 1 : ((colors_r > MAX_COLORS) ? MAX_COLORS : colors_r);
    grid = (grid_r < 1) ? 1 : ((grid_r > MAX_GRID) ? MAX_GRID : grid_r);
    na   = (anchors_r < 1) ? 1 : ((anchors_r > MAX_ANCHORS) ? MAX_ANCHORS : anchors_r);
    n = FIXED_CH + nc + ncol;
    ch = chan;
    if (ch < NUM_BOX) box_p[ch] = sigmoid_q16(x);
    else if (ch < FIXED_CH) key_off[ch - NUM_BOX] = x;
    else if (ch < FIXED_CH + nc) begin
      sv = sigmoid_q16(x);
      if (ch == FIXED_CH || sv > cls_best) begin
        cls_best = sv; cls_idx = ch - FIXED_CH;
      end
    end else begin
      sv = sigmoid_q16(x);
      if (ch == FIXED_CH + nc || sv > colr_best) begin
        colr_best = sv; colr_idx = ch - FIXED_CH - nc;
      end
    end
    if (ch + 1 < n) begin
      chan = ch + 1;
      return;
    end
    // end of cell: capture position, then step column/row/anchor
    chan = 0;
    c = col; r = row; a = anc;
    if (col + 1 >= grid) begin
      col = 0;
      if (row + 1 >= grid) begin
        row = 0;
        anc = (anc + 1 >= na) ? 0 : anc + 1;
      end else row++;
    end else col++;
    rt = root32(longint'(cls_best) * colr_best);
    conf = (longint'(box_p[4]) * rt) >> 16;
    if (conf <= thresh_r) return;
    s = 1 << stride_r;
    aw = (a < 3) ? longint'((asize_r >> (20 * a)) & 1023) : 0;
    ah = (a < 3) ? longint'((asize_r >> (20 * a + 10)) & 1023) : 0;
    xc = (2 * longint'(box_p[0]) - 32768 + longint'(c) * 65536) * longint'(s);
    yc = (2 * longint'(box_p[1]) - 32768 + longint'(r) * 65536) * longint'(s);
    sqw = 2 * longint'(box_p[2]); sqw = sqw * sqw;
    sqh = 2 * longint'(box_p[3]); sqh = sqh * sqh;
    px[0] = (xc * 524288 - sqw * aw) >>> 31;
    py[0] = (yc * 524288 - sqh * ah) >>> 31;
    px[1] = (xc * 524288 + sqw * aw) >>> 31;
    py[1] = (yc * 524288 + sqh * ah) >>> 31;
    for (int k = 0; k < 5; k++) begin
      px[2 + k] = (key_off[2 * k] * aw + longint'(c) * longint'(s) * 1024) >>> 6;
      py[2 + k] = (key_off[2 * k + 1] * ah + longint'(r) * longint'(s) * 1024) >>> 6;
    end
    for (int k = 0; k < 7; k++) begin
      pt.kind = k;
      pt.x = clip(px[k]);
      pt.y = clip(py[k]);
      pt.conf = conf[15:0];
      pt.cls = cls_idx[CLS_W-1:0];
      pt.colr = colr_idx[COLR_W-1:0];
      pt.last = (k == 6);
      point_q = {point_q, pt};
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("%0t point mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      grid_r = 80; stride_r = 3; anchors_r = 3; classes_r = 8; colors_r = 4;
      thresh_r = 32768; asize_r = '0;
      chan = 0; col = 0; row = 0; anc = 0;
      cls_best = 0; cls_idx = 0; colr_best = 0; colr_idx = 0;
      foreach (box_p[i]) box_p[i] = 0;
      foreach (key_off[i]) key_off[i] = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_SIZE:      grid_r = cfg_data[8:0];
          CFG_STRIDE_LOG2:    stride_r = cfg_data[2:0];
          CFG_NUM_ANCHORS:    anchors_r = cfg_data[1:0];
          CFG_NUM_CLASSES:    classes_r = cfg_data[4:0];
          CFG_NUM_COLORS:     colors_r = cfg_data[3:0];
          CFG_CONF_THRESHOLD: thresh_r = cfg_data[15:0];
          CFG_ANCHOR_SIZES:   asize_r = cfg_data[59:0];
          default: ;
        endcase
      end
      if (logit_ch.valid && logit_ch.ready)
        decode_beat(logit_ch.logit, logit_ch.first_of_layer);
      if (point_ch.valid && point_ch.ready) begin
        if (point_q.size() == 0) begin
          report("unexpected point_kind", point_ch.point_kind, -1);
        end else begin
          point_t w;
          w = point_q.pop_front();
          if (point_ch.point_kind !== w.kind) report("point_kind", point_ch.point_kind, w.kind);
          if (point_ch.x_coord !== w.x) report("x_coord", point_ch.x_coord, w.x);
          if (point_ch.y_coord !== w.y) report("y_coord", point_ch.y_coord, w.y);
          if (point_ch.confidence !== w.conf) report("confidence", point_ch.confidence, w.conf);
          if (point_ch.class_id !== w.cls) report("class_id", point_ch.class_id, w.cls);
          if (point_ch.color_id !== w.colr) report("color_id", point_ch.color_id, w.colr);
          if (point_ch.last_of_detection !== w.last)
            report("last_of_detection", point_ch.last_of_detection, w.last);
        end
      end
    end
    pending = point_q.size();
  end
endmodule

FILE: dv/anchor_box_detection_decoder_top_tb.sv
// Testbench top for the anchor box detection decoder: clock, reset, logit
// stimulus, point sink with random stalls, and the final verdict.
// Depends on abd_pkg, abd_in_if, abd_out_if, abd_checker and the block itself.
module anchor_box_detection_decoder_top_tb;
  import abd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // worst drain time after the last beat: sigmoid + root + seven stalled points
  localparam int DRAIN_CYCLES = 400;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    beats_sent;
  bit                    calm;   // no idling on either side near the end

  abd_in_if  logit_ch ();
  abd_out_if point_ch ();

  anchor_box_detection_decoder_top dut (
    .clk(clk), .rst(rst), .in(logit_ch), .out(point_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  abd_checker chk (
    .clk(clk), .rst(rst), .logit_ch(logit_ch), .point_ch(point_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("anchor_box_detection_decoder_top: mismatch");
    $finish;
  end

  // Point sink: ready drops in random bursts until the calm tail.
  initial begin
    point_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        point_ch.ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      point_ch.ready = 1'b1;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One logit beat; holds valid until the block takes it.
  task automatic send_logit(logic signed [15:0] v, logic first);
    @(negedge clk);
    logit_ch.valid = 1'b1;
    logit_ch.logit = v;
    logit_ch.first_of_layer = first;
    do @(posedge clk); while (!logit_ch.ready);
    beats_sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      logit_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // Wait until every predicted point has arrived and the block has settled.
  task automatic drain();
    @(negedge clk);
    logit_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [59:0] rand_anchors();
    return 60'({$urandom, $urandom});
  endfunction

  // Class/color logits, half from a narrow range so ties and first-max hold show up.
  function automatic logic signed [15:0] score_logit();
    if ($urandom_range(0, 1)) return 16'($signed($urandom_range(0, 6)) * 256 - 512);
    return 16'($urandom);
  endfunction

  // A well-formed cell; obj score leans high so many cells pass.
  task automatic send_cell(int n, logic first);
    logic signed [15:0] v;
    for (int ch = 0; ch < n; ch++) begin
      if (ch == 4) v = $urandom_range(0, 3) ? 16'($urandom_range(256, 32767)) : 16'($urandom);
      else if (ch >= FIXED_CH) v = score_logit();
      else v = 16'($urandom);
      send_logit(v, first && ch == 0);
    end
  endtask

  initial begin
    int nc, ncol, cells;
    logic [8:0] g;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_GRID_SIZE;
    cfg_data = '0;
    logit_ch.valid = 1'b0;
    logit_ch.logit = '0;
    logit_ch.first_of_layer = 1'b0;
    beats_sent = 0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: smallest cell, zero threshold, field extremes.
    write_reg(CFG_GRID_SIZE, 2);
    write_reg(CFG_STRIDE_LOG2, 2);
    write_reg(CFG_NUM_ANCHORS, 3);
    write_reg(CFG_NUM_CLASSES, 1);
    write_reg(CFG_NUM_COLORS, 1);
    write_reg(CFG_CONF_THRESHOLD, 0);
    write_reg(CFG_ANCHOR_SIZES, 60'hFFF_FFFF_FFFF_FFFF);
    send_logit(16'sh7FFF, 1'b1);   // box x max
    send_logit(-16'sh8000, 1'b0);  // box y min
    send_logit(16'sh0000, 1'b0);
    send_logit(-16'sh0001, 1'b0);
    send_logit(16'sh7FFF, 1'b0);   // obj max
    for (int k = 0; k < 10; k++)   // keypoints that saturate both ways
      send_logit(k[0] ? -16'sh8000 : 16'sh7FFF, 1'b0);
    send_logit(16'sh0001, 1'b0);
    send_logit(16'sh7FFF, 1'b0);
    // all-negative cell: confidence falls to zero and cannot pass
    for (int k = 0; k < 17; k++) send_logit(-16'sh8000, 1'b0);
    drain();

    // Random phases: new settings each time, mostly well-formed cells.
    while (beats_sent < 380) begin
      if (beats_sent > 300) calm = 1'b1;
      case ($urandom_range(0, 5))
        0: g = 0;
        1: g = 9'd511;                       // clamps to the grid limit
        2: g = 9'd256;
        default: g = $urandom_range(1, 3);
      endcase
      write_reg(CFG_GRID_SIZE, g);
      write_reg(CFG_STRIDE_LOG2, $urandom_range(0, 7));
      write_reg(CFG_NUM_ANCHORS, $urandom_range(0, 3));
      nc = $urandom_range(0, 3) ? $urandom_range(1, 4) : $urandom_range(0, 31);
      ncol = $urandom_range(0, 3) ? $urandom_range(1, 3) : $urandom_range(0, 15);
      write_reg(CFG_NUM_CLASSES, nc);
      write_reg(CFG_NUM_COLORS, ncol);
      write_reg(CFG_CONF_THRESHOLD, $urandom_range(0, 3) ? $urandom_range(0, 20000)
                                                         : $urandom_range(0, 65535));
      write_reg(CFG_ANCHOR_SIZES, $urandom_range(0, 5) ? rand_anchors() : '0);
      nc = (nc < 1) ? 1 : ((nc > MAX_CLASSES) ? MAX_CLASSES : nc);
      ncol = (ncol < 1) ? 1 : ((ncol > MAX_COLORS) ? MAX_COLORS : ncol);
      cells = $urandom_range(1, 4);
      for (int c = 0; c < cells; c++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: a broken run of raw beats with random layer restarts
          repeat ($urandom_range(1, 12)) send_logit(16'($urandom), $urandom_range(0, 3) == 0);
        end else begin
          send_cell(FIXED_CH + nc + ncol, c == 0 && $urandom_range(0, 1));
        end
      end
      // sometimes stop mid-cell so the next settings land inside a cell
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 20)) send_logit(16'($urandom), 1'b0);
      drain();
    end

    if (errors == 0) begin
      $display("anchor_box_detection_decoder_top: match");
    end else begin
      $display("anchor_box_detection_decoder_top: mismatch");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hdl/abd_pkg.sv
hdl/abd_in_if.sv
hdl/abd_out_if.sv
hdl/abd_ctrl.sv
hdl/abd_dp.sv
hdl/anchor_box_detection_decoder_top.sv
dv/abd_checker.sv
dv/anchor_box_detection_decoder_top_tb.sv
